// ----- rtl/dtsf_pkg.sv -----
package dtsf_pkg;

    // Event kinds carried in the input tuser.
    localparam logic [1:0] REQ_BEGIN    = 2'd0;
    localparam logic [1:0] REQ_OBSERVE  = 2'd1;
    localparam logic [1:0] REQ_SNAPSHOT = 2'd2;
    localparam logic [1:0] REQ_CHECK    = 2'd3;

    // Settling state codes, as reported in fsm_state.
    localparam logic [2:0] ST_STABLE_KNOWN   = 3'd0;
    localparam logic [2:0] ST_STABLE_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_RECONFIG       = 3'd2;
    localparam logic [2:0] ST_GRACE          = 3'd3;
    localparam logic [2:0] ST_UNAVAIL        = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE = 8'd1;

    localparam logic [31:0] QUIET_RESET = 32'd2000;
    localparam logic [31:0] GRACE_RESET = 32'd10000;

    localparam logic [63:0] TIME_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NO_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int unsigned IN_DATA_W  = 136;
    localparam int unsigned OUT_DATA_W = 72;

endpackage

// ----- rtl/display_topology_settle_fsm_unit.sv -----
// Display layout settling state machine.
//
// Events arrive on the slave stream: tuser carries the event kind (begin
// reconfiguration, observe, reconfiguration snapshot, deadline check) and
// tdata carries the time stamp, the empty-layout flag, the layout key and
// the known-profile flag. Every accepted beat yields exactly one decision
// beat on the master stream, in order.
//
// The block is two register stages deep: an input register, then the state
// update and the result register, which registers the decision. One event
// per cycle is sustained while the receiver keeps tready high, since the
// state update with its compares and two saturating adds is combinational.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more event before tready drops.
//
// The configuration channel is always ready; quiet and grace periods are
// meant to be written while no events are in flight. Synchronous reset puts
// the state in unavailable with no deadline and restores the default
// periods (2000 ms quiet, 10000 ms grace).
module display_topology_settle_fsm_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Event stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: now_ms[62:0], no_display[63], layout_key[127:64],
    // profile_known[128], zero fill[135:129]
    input  logic [dtsf_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                           i_s_tuser,
    // Decision stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata: fsm_state[2:0], apply_profile[3], disconnect_clients[4],
    // is_stable[5], deadline_ms[69:6], zero fill[71:70]
    output logic [dtsf_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dtsf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    logic [31:0] r_quiet;
    logic [31:0] r_grace;

    // Input stage.
    logic        r_in_valid;
    logic [1:0]  r_req;
    logic [62:0] r_now;
    logic        r_empty;
    logic [63:0] r_key;
    logic        r_known;

    // Settling state.
    logic [2:0]  r_mode;
    logic [63:0] r_deadline;
    logic        r_cap_pend;
    logic        r_have;
    logic        r_last_empty;
    logic        r_known_prof;
    logic [63:0] r_stored_key;

    logic [2:0]  n_mode;
    logic [63:0] n_deadline;
    logic        n_cap_pend;
    logic        n_have;
    logic        n_last_empty;
    logic        n_known_prof;
    logic [63:0] n_stored_key;
    logic        n_disc;

    // Output stage.
    logic        r_out_valid;
    logic [dtsf_pkg::OUT_DATA_W-1:0] r_out_data;

    logic        advance;
    logic        s_accept;
    logic [63:0] quiet_sum;
    logic [63:0] grace_sum;
    logic [63:0] quiet_dl;
    logic [63:0] grace_dl;
    logic        before_dl;
    logic        past_dl;
    logic        same_key;
    logic [63:0] out_dl;

    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || advance;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet <= dtsf_pkg::QUIET_RESET;
            r_grace <= dtsf_pkg::GRACE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dtsf_pkg::CFG_QUIET) begin
                r_quiet <= i_cfg_data;
            end else if (i_cfg_index == dtsf_pkg::CFG_GRACE) begin
                r_grace <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req   <= i_s_tuser;
            r_now   <= i_s_tdata[62:0];
            r_empty <= i_s_tdata[63];
            r_key   <= i_s_tdata[127:64];
            r_known <= i_s_tdata[128];
        end
    end

    // The time stamp is below 2^63 and the delay below 2^32, so the sum fits
    // in 64 bits and its top bit marks saturation.
    assign quiet_sum = {1'b0, r_now} + {32'd0, r_quiet};
    assign grace_sum = {1'b0, r_now} + {32'd0, r_grace};
    assign quiet_dl  = quiet_sum[63] ? dtsf_pkg::TIME_MAX : quiet_sum;
    assign grace_dl  = grace_sum[63] ? dtsf_pkg::TIME_MAX : grace_sum;

    // A negative deadline means none: never before it, never past it.
    assign before_dl = !r_deadline[63] && (r_now < r_deadline[62:0]);
    assign past_dl   = !r_deadline[63] && (r_now >= r_deadline[62:0]);
    assign same_key  = r_have && !r_last_empty && (r_key == r_stored_key);

    always_comb begin
        n_mode       = r_mode;
        n_deadline   = r_deadline;
        n_cap_pend   = r_cap_pend;
        n_have       = r_have;
        n_last_empty = r_last_empty;
        n_known_prof = r_known_prof;
        n_stored_key = r_stored_key;
        n_disc       = 1'b0;

        case (r_req)
            dtsf_pkg::REQ_BEGIN: begin
                n_cap_pend = 1'b1;
                if (r_mode != dtsf_pkg::ST_GRACE && r_mode != dtsf_pkg::ST_UNAVAIL) begin
                    n_mode     = dtsf_pkg::ST_RECONFIG;
                    n_deadline = dtsf_pkg::NO_DEADLINE;
                end
            end
            dtsf_pkg::REQ_OBSERVE, dtsf_pkg::REQ_SNAPSHOT: begin
                // A plain observation while a capture is pending may be
                // stale data and is ignored.
                if (r_req == dtsf_pkg::REQ_OBSERVE && r_cap_pend) begin
                    n_mode = r_mode;
                end else if (r_empty) begin
                    n_cap_pend = 1'b0;
                    if (r_last_empty) begin
                        if (r_mode == dtsf_pkg::ST_GRACE && past_dl) begin
                            n_mode     = dtsf_pkg::ST_UNAVAIL;
                            n_deadline = dtsf_pkg::NO_DEADLINE;
                            n_disc     = 1'b1;
                        end
                    end else begin
                        n_last_empty = 1'b1;
                        n_mode       = dtsf_pkg::ST_GRACE;
                        n_deadline   = grace_dl;
                    end
                end else begin
                    n_known_prof = r_known;
                    n_last_empty = 1'b0;
                    n_have       = 1'b1;
                    if (r_req == dtsf_pkg::REQ_SNAPSHOT || !same_key) begin
                        if (r_req == dtsf_pkg::REQ_SNAPSHOT) begin
                            n_cap_pend = 1'b0;
                        end
                        n_stored_key = r_key;
                        n_mode       = dtsf_pkg::ST_RECONFIG;
                        n_deadline   = quiet_dl;
                    end else if (r_mode != dtsf_pkg::ST_RECONFIG) begin
                        n_mode     = r_known ? dtsf_pkg::ST_STABLE_KNOWN
                                             : dtsf_pkg::ST_STABLE_UNKNOWN;
                        n_deadline = dtsf_pkg::NO_DEADLINE;
                    end
                end
            end
            default: begin
                if (!r_cap_pend && !before_dl) begin
                    if (r_mode == dtsf_pkg::ST_RECONFIG) begin
                        n_mode     = r_known_prof ? dtsf_pkg::ST_STABLE_KNOWN
                                                  : dtsf_pkg::ST_STABLE_UNKNOWN;
                        n_deadline = dtsf_pkg::NO_DEADLINE;
                    end else if (r_mode == dtsf_pkg::ST_GRACE) begin
                        n_mode     = dtsf_pkg::ST_UNAVAIL;
                        n_deadline = dtsf_pkg::NO_DEADLINE;
                        n_disc     = 1'b1;
                    end
                end
            end
        endcase
    end

    // The reported deadline is shown only where a check can still act.
    always_comb begin
        out_dl = dtsf_pkg::NO_DEADLINE;
        if (n_mode == dtsf_pkg::ST_RECONFIG) begin
            out_dl = n_deadline;
        end else if (n_mode == dtsf_pkg::ST_GRACE && !n_cap_pend) begin
            out_dl = n_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= dtsf_pkg::ST_UNAVAIL;
            r_deadline   <= dtsf_pkg::NO_DEADLINE;
            r_cap_pend   <= 1'b0;
            r_have       <= 1'b0;
            r_last_empty <= 1'b0;
            r_known_prof <= 1'b0;
            r_stored_key <= 64'd0;
            r_out_valid  <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_mode       <= n_mode;
                r_deadline   <= n_deadline;
                r_cap_pend   <= n_cap_pend;
                r_have       <= n_have;
                r_last_empty <= n_last_empty;
                r_known_prof <= n_known_prof;
                r_stored_key <= n_stored_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data <= {
                2'b00,
                out_dl,
                (n_mode == dtsf_pkg::ST_STABLE_KNOWN || n_mode == dtsf_pkg::ST_STABLE_UNKNOWN),
                n_disc,
                (n_mode == dtsf_pkg::ST_STABLE_KNOWN),
                n_mode
            };
        end
    end

endmodule

// ----- rtl/dtsf_checker.sv -----
module dtsf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_tvalid,
    input logic                              i_out_tready,
    input logic [dtsf_pkg::OUT_DATA_W-1:0]   i_out_tdata
);

    // A stalled decision beat stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_out_tready |=> i_out_tvalid && $stable(i_out_tdata))
        else $error("decision beat changed while stalled");

    // Applying a profile only happens in the stable known state.
    a_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && i_out_tdata[3] |-> i_out_tdata[2:0] == dtsf_pkg::ST_STABLE_KNOWN)
        else $error("apply_profile outside stable known");

    // The stable flag agrees with the state code.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid |-> i_out_tdata[5] ==
            (i_out_tdata[2:0] == dtsf_pkg::ST_STABLE_KNOWN ||
             i_out_tdata[2:0] == dtsf_pkg::ST_STABLE_UNKNOWN))
        else $error("is_stable disagrees with fsm_state");

    // Clients are dropped only on entry to unavailable, which has no deadline.
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && i_out_tdata[4] |->
            i_out_tdata[2:0] == dtsf_pkg::ST_UNAVAIL &&
            i_out_tdata[69:6] == dtsf_pkg::NO_DEADLINE)
        else $error("disconnect without a move to unavailable");

    // Stable states never report a pending deadline.
    a_no_dl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && i_out_tdata[5] |-> i_out_tdata[69:6] == dtsf_pkg::NO_DEADLINE)
        else $error("deadline reported in a stable state");

endmodule

bind display_topology_settle_fsm_unit dtsf_checker u_dtsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (o_m_tvalid),
    .i_out_tready (i_m_tready),
    .i_out_tdata  (o_m_tdata)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 1000;
    localparam logic [dtsf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'hFE;

    typedef struct {
        logic [2:0]  fsm_state;
        logic        apply_profile;
        logic        disconnect;
        logic        is_stable;
        logic [63:0] deadline_ms;
    } t_decision;

    // Tracks the settling state of the layout and holds the decisions still owed.
    class t_settle_scoreboard;
        logic [31:0] quiet;
        logic [31:0] grace;
        logic [2:0]  mode;
        logic [63:0] deadline;
        bit          capture_pending;
        bit          have_layout;
        bit          last_empty;
        bit          known;
        logic [63:0] layout_key;
        t_decision   awaited_decisions[$];
        int          errors;

        function new();
            quiet           = dtsf_pkg::QUIET_RESET;
            grace           = dtsf_pkg::GRACE_RESET;
            mode            = dtsf_pkg::ST_UNAVAIL;
            deadline        = dtsf_pkg::NO_DEADLINE;
            capture_pending = 1'b0;
            have_layout     = 1'b0;
            last_empty      = 1'b0;
            known           = 1'b0;
            layout_key      = '0;
            errors          = 0;
        endfunction

        function void write_period(logic [dtsf_pkg::CFG_IDX_W-1:0] idx,
                                   logic [31:0] value);
            if (idx == dtsf_pkg::CFG_QUIET)
                quiet = value;
            else if (idx == dtsf_pkg::CFG_GRACE)
                grace = value;
        endfunction

        function logic [63:0] saturated_after(logic [63:0] now, logic [31:0] delay);
            if (now > dtsf_pkg::TIME_MAX - {32'd0, delay})
                return dtsf_pkg::TIME_MAX;
            return now + {32'd0, delay};
        endfunction

        // A negative deadline means none is set, so nothing is ever early for it.
        function bit early(logic [63:0] now);
            return !deadline[63] && now < deadline;
        endfunction

        function void predict_decision(logic [1:0] req,
                                       logic [dtsf_pkg::IN_DATA_W-1:0] beat);
            logic [63:0] now;
            logic        empty;
            logic [63:0] key_in;
            logic        known_in;
            bit          same;
            bit          disc;
            t_decision   d;
            now      = {1'b0, beat[62:0]};
            empty    = beat[63];
            key_in   = beat[127:64];
            known_in = beat[128];
            disc     = 1'b0;
            case (req)
                dtsf_pkg::REQ_BEGIN: begin
                    capture_pending = 1'b1;
                    if (mode != dtsf_pkg::ST_GRACE && mode != dtsf_pkg::ST_UNAVAIL) begin
                        mode     = dtsf_pkg::ST_RECONFIG;
                        deadline = dtsf_pkg::NO_DEADLINE;
                    end
                end
                dtsf_pkg::REQ_CHECK: begin
                    if ((mode == dtsf_pkg::ST_RECONFIG || mode == dtsf_pkg::ST_GRACE)
                            && !capture_pending && !early(now)) begin
                        if (mode == dtsf_pkg::ST_RECONFIG) begin
                            mode = known ? dtsf_pkg::ST_STABLE_KNOWN
                                         : dtsf_pkg::ST_STABLE_UNKNOWN;
                        end else begin
                            mode = dtsf_pkg::ST_UNAVAIL;
                            disc = 1'b1;
                        end
                        deadline = dtsf_pkg::NO_DEADLINE;
                    end
                end
                default: begin
                    // A plain observe during a pending capture may be stale and is dropped.
                    if (req == dtsf_pkg::REQ_OBSERVE && capture_pending) begin
                    end else if (empty) begin
                        capture_pending = 1'b0;
                        if (!last_empty) begin
                            last_empty = 1'b1;
                            mode       = dtsf_pkg::ST_GRACE;
                            deadline   = saturated_after(now, grace);
                        end else if (mode == dtsf_pkg::ST_GRACE && !deadline[63]
                                && now >= deadline) begin
                            mode     = dtsf_pkg::ST_UNAVAIL;
                            deadline = dtsf_pkg::NO_DEADLINE;
                            disc     = 1'b1;
                        end
                    end else begin
                        same        = have_layout && !last_empty && key_in == layout_key;
                        known       = known_in;
                        last_empty  = 1'b0;
                        have_layout = 1'b1;
                        if (req == dtsf_pkg::REQ_SNAPSHOT || !same) begin
                            capture_pending = 1'b0;
                            layout_key      = key_in;
                            mode            = dtsf_pkg::ST_RECONFIG;
                            deadline        = saturated_after(now, quiet);
                        end else if (mode != dtsf_pkg::ST_RECONFIG) begin
                            mode     = known_in ? dtsf_pkg::ST_STABLE_KNOWN
                                                : dtsf_pkg::ST_STABLE_UNKNOWN;
                            deadline = dtsf_pkg::NO_DEADLINE;
                        end
                    end
                end
            endcase
            d.fsm_state     = mode;
            d.apply_profile = (mode == dtsf_pkg::ST_STABLE_KNOWN);
            d.disconnect    = disc;
            d.is_stable     = (mode == dtsf_pkg::ST_STABLE_KNOWN ||
                               mode == dtsf_pkg::ST_STABLE_UNKNOWN);
            d.deadline_ms   = dtsf_pkg::NO_DEADLINE;
            if (mode == dtsf_pkg::ST_RECONFIG ||
                    (mode == dtsf_pkg::ST_GRACE && !capture_pending))
                d.deadline_ms = deadline;
            awaited_decisions.push_back(d);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
            errors++;
        endtask

        task check_decision(logic [dtsf_pkg::OUT_DATA_W-1:0] beat);
            t_decision want;
            if (awaited_decisions.size() == 0) begin
                report("unrequested decision", beat[63:0], '0);
            end else begin
                want = awaited_decisions.pop_front();
                if (beat[2:0] !== want.fsm_state)
                    report("fsm_state", 64'(beat[2:0]), 64'(want.fsm_state));
                if (beat[3] !== want.apply_profile)
                    report("apply_profile", 64'(beat[3]), 64'(want.apply_profile));
                if (beat[4] !== want.disconnect)
                    report("disconnect_clients", 64'(beat[4]), 64'(want.disconnect));
                if (beat[5] !== want.is_stable)
                    report("is_stable", 64'(beat[5]), 64'(want.is_stable));
                if (beat[69:6] !== want.deadline_ms)
                    report("deadline_ms", beat[69:6], want.deadline_ms);
            end
        endtask
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [dtsf_pkg::IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [1:0]                      i_s_tuser   = dtsf_pkg::REQ_BEGIN;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [dtsf_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [dtsf_pkg::CFG_IDX_W-1:0]  i_cfg_index = dtsf_pkg::CFG_QUIET;
    logic [31:0]                     i_cfg_data  = '0;

    t_settle_scoreboard sb;
    bit                 no_idle = 1'b0;
    logic [31:0]        cur_quiet = dtsf_pkg::QUIET_RESET;
    logic [31:0]        cur_grace = dtsf_pkg::GRACE_RESET;
    logic [62:0]        t_now = '0;
    logic [63:0]        key_pool[4];
    int                 stall_cycles = 0;

    display_topology_settle_fsm_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_decision(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Decision receiver: drops tready for a random stall before each beat, except in the no-idle phases.
    initial begin
        int hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold != 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic send_event(input logic [1:0] req, input logic [62:0] now,
                              input logic empty, input logic [63:0] key,
                              input logic known);
        int                             gap;
        logic [dtsf_pkg::IN_DATA_W-1:0] beat;
        gap  = no_idle ? 0 : $urandom_range(0, 7);
        beat = {7'd0, known, key, empty, now};
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_tready);
        sb.predict_decision(req, beat);
    endtask

    // Stops the event stream and waits until every owed decision has come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.awaited_decisions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dtsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_period(idx, value);
    endtask

    task automatic set_periods(input logic [31:0] quiet, input logic [31:0] grace);
        write_reg(dtsf_pkg::CFG_QUIET, quiet);
        write_reg(dtsf_pkg::CFG_GRACE, grace);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
        cur_quiet = quiet;
        cur_grace = grace;
    endtask

    // Mostly reconfiguration episodes over a few recurring layouts, with time
    // steps scaled to the current periods so that deadlines are both met and missed.
    task automatic run_random(input int count);
        logic [1:0]  req;
        logic [63:0] key;
        logic [63:0] wide;
        logic [62:0] stamp;
        logic [31:0] adv;
        bit          want_snap;
        int          pick;
        want_snap = 1'b0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (want_snap && pick < 70)
                req = dtsf_pkg::REQ_SNAPSHOT;
            else if (pick < 12)
                req = dtsf_pkg::REQ_BEGIN;
            else if (pick < 50)
                req = dtsf_pkg::REQ_OBSERVE;
            else if (pick < 65)
                req = dtsf_pkg::REQ_SNAPSHOT;
            else
                req = dtsf_pkg::REQ_CHECK;
            want_snap = (req == dtsf_pkg::REQ_BEGIN);
            case ($urandom_range(0, 9))
                0:       adv = '0;
                1, 2, 3: adv = $urandom_range(0, 16);
                4, 5, 6: adv = $urandom_range(0, cur_quiet);
                7, 8:    adv = $urandom_range(0, cur_grace);
                default: adv = $urandom_range(0, 1) ? cur_quiet : cur_grace;
            endcase
            t_now = t_now + {31'd0, adv};
            pick  = $urandom_range(0, 99);
            if (pick < 2)
                t_now = dtsf_pkg::TIME_MAX[62:0] - 63'($urandom_range(0, 3000));
            wide  = {$urandom, $urandom};
            stamp = (pick >= 97) ? wide[62:0] : t_now;
            key   = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, 3)];
            send_event(req, stamp, $urandom_range(0, 99) < 15, key,
                       1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [62:0] tmax;
        logic [31:0] quiet_set[7];
        logic [31:0] grace_set[7];
        sb   = new();
        tmax = dtsf_pkg::TIME_MAX[62:0];
        key_pool[0] = '0;
        for (int i = 1; i < 4; i++)
            key_pool[i] = {$urandom, $urandom};
        quiet_set = '{32'd50, 32'd0, 32'hFFFF_FFFF, 32'd0,
                      $urandom_range(1, 100), dtsf_pkg::QUIET_RESET, $urandom};
        grace_set = '{32'd300, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      $urandom_range(100, 5000), dtsf_pkg::GRACE_RESET, $urandom};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the reset periods of 2000 and 10000.
        send_event(dtsf_pkg::REQ_CHECK,    63'd0,     1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd100,   1'b1, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd200,   1'b1, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_CHECK,    63'd5000,  1'b0, 64'd0,        1'b0);
        // Still empty at the grace deadline: disconnect without a check.
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd10100, 1'b1, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd10200, 1'b0, key_pool[1],  1'b1);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd10300, 1'b0, key_pool[1],  1'b1);
        send_event(dtsf_pkg::REQ_CHECK,    63'd12199, 1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_CHECK,    63'd12200, 1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd12300, 1'b0, key_pool[1],  1'b0);
        send_event(dtsf_pkg::REQ_BEGIN,    63'd12400, 1'b1, '1,           1'b1);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd12500, 1'b0, key_pool[2],  1'b1);
        send_event(dtsf_pkg::REQ_CHECK,    tmax,      1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_SNAPSHOT, 63'd13000, 1'b0, key_pool[2],  1'b1);
        send_event(dtsf_pkg::REQ_CHECK,    tmax,      1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  tmax - 63'd5, 1'b0, key_pool[1], 1'b0);
        send_event(dtsf_pkg::REQ_CHECK,    tmax,      1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd20000, 1'b1, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_BEGIN,    63'd20100, 1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_CHECK,    63'd40000, 1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_SNAPSHOT, 63'd40000, 1'b1, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_BEGIN,    63'd40100, 1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_SNAPSHOT, tmax,      1'b0, '1,           1'b1);
        send_event(dtsf_pkg::REQ_CHECK,    63'd0,     1'b0, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_OBSERVE,  63'd50000, 1'b1, 64'd0,        1'b0);
        send_event(dtsf_pkg::REQ_CHECK,    63'd60000, 1'b0, 64'd0,        1'b0);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            set_periods(quiet_set[phase], grace_set[phase]);
            no_idle = (phase % 3 == 1);
            run_random(140);
            drain();
            run_random(145);
            drain();
        end

        if (sb.awaited_decisions.size() != 0)
            sb.report("decisions never delivered", 64'(sb.awaited_decisions.size()), '0);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
